### rtl/core/switch_debouncer_top_defines.svh
// ----------------------------------------------------------------------------
// switch_debouncer_top_defines.svh
// Assertion macros shared by the switch debouncer RTL.
// ----------------------------------------------------------------------------
`ifndef SWITCH_DEBOUNCER_TOP_DEFINES_SVH
`define SWITCH_DEBOUNCER_TOP_DEFINES_SVH

// Checked on clk_i, off while rst_ni is low.
`define SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on clk_i at every edge, reset included.
`define SD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/core/sd_pkg.sv
// ----------------------------------------------------------------------------
// sd_pkg
// Types and constants of the switch debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sd_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [IntervalW-1:0] IntervalRst = IntervalW'(10);

  typedef enum logic [ModeW-1:0] {
    MODE_STABLE  = 2'd0,
    MODE_LOCKOUT = 2'd1,
    MODE_PROMPT  = 2'd2
  } sd_mode_e;

  typedef enum logic {
    OP_UPDATE  = 1'b0,
    OP_RESTART = 1'b1
  } sd_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INTERVAL = 1'b0,
    CFG_MODE     = 1'b1
  } sd_cfg_idx_e;

  typedef struct packed {
    logic             operation;
    logic             pin_level;
    logic [TimeW-1:0] now_ms;
  } sd_item_t;

  typedef struct packed {
    logic             level;
    logic             changed;
    logic             rose;
    logic             fell;
    logic [TimeW-1:0] previous_duration;
    logic [TimeW-1:0] current_duration;
  } sd_result_t;

  typedef struct packed {
    logic [IntervalW-1:0] interval_ms;
    logic [ModeW-1:0]     mode;
  } sd_cfg_t;

endpackage

### rtl/core/sd_in_stage.sv
// ----------------------------------------------------------------------------
// sd_in_stage
// Input register: captures one item per transfer, holds it until consumed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sd_in_stage import sd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sd_item_t item_i,
  output logic     valid_o,
  input  logic     take_i,
  output sd_item_t item_o
);

  logic     valid_q, valid_d;
  sd_item_t item_q;
  logic     load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/core/sd_core.sv
// ----------------------------------------------------------------------------
// sd_core
// Debounce state and its combinational next-state update for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "switch_debouncer_top_defines.svh"

module sd_core import sd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       proc_i,
  input  sd_item_t   item_i,
  input  sd_cfg_t    cfg_i,
  output sd_result_t result_o
);

  logic             deb_q, deb_d;
  logic             raw_q, raw_d;
  logic [TimeW-1:0] start_q, start_d;
  logic [TimeW-1:0] lct_q, lct_d;
  logic [TimeW-1:0] ldur_q, ldur_d;
  logic             chg;
  logic             elapsed;
  logic [TimeW-1:0] since_start;

  assign since_start = item_i.now_ms - start_q;
  assign elapsed     = since_start >= {{(TimeW-IntervalW){1'b0}}, cfg_i.interval_ms};

  always_comb begin
    deb_d   = deb_q;
    raw_d   = raw_q;
    start_d = start_q;
    lct_d   = lct_q;
    ldur_d  = ldur_q;
    chg     = 1'b0;
    if (item_i.operation == OP_RESTART) begin
      deb_d   = item_i.pin_level;
      raw_d   = item_i.pin_level;
      start_d = (cfg_i.mode == MODE_LOCKOUT) ? '0 : item_i.now_ms;
    end else begin
      unique case (cfg_i.mode)
        MODE_LOCKOUT: begin
          if (elapsed && item_i.pin_level != deb_q) begin
            start_d = item_i.now_ms;
            chg     = 1'b1;
          end
        end
        MODE_PROMPT: begin
          if (elapsed && item_i.pin_level != deb_q) begin
            chg = 1'b1;
          end
          if (item_i.pin_level != raw_q) begin
            raw_d   = item_i.pin_level;
            start_d = item_i.now_ms;
          end
        end
        default: begin
          if (item_i.pin_level != raw_q) begin
            raw_d   = item_i.pin_level;
            start_d = item_i.now_ms;
          end else if (elapsed && item_i.pin_level != deb_q) begin
            start_d = item_i.now_ms;
            chg     = 1'b1;
          end
        end
      endcase
      if (chg) begin
        deb_d  = ~deb_q;
        ldur_d = item_i.now_ms - lct_q;
        lct_d  = item_i.now_ms;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q   <= 1'b0;
      raw_q   <= 1'b0;
      start_q <= '0;
      lct_q   <= '0;
      ldur_q  <= '0;
    end else if (proc_i) begin
      deb_q   <= deb_d;
      raw_q   <= raw_d;
      start_q <= start_d;
      lct_q   <= lct_d;
      ldur_q  <= ldur_d;
    end
  end

  assign result_o.level             = deb_d;
  assign result_o.changed           = chg;
  assign result_o.rose              = chg & deb_d;
  assign result_o.fell              = chg & ~deb_d;
  assign result_o.previous_duration = ldur_d;
  assign result_o.current_duration  = item_i.now_ms - lct_d;

  `SD_ASSERT(a_chg_toggles, proc_i && chg |=> deb_q != $past(deb_q), "change did not toggle level")
  `SD_ASSERT(a_chg_stamps, proc_i && chg |=> lct_q == $past(item_i.now_ms), "change time not taken")
  `SD_ASSERT(a_lockout_raw,
    proc_i && item_i.operation == OP_UPDATE && cfg_i.mode == MODE_LOCKOUT |=> $stable(raw_q),
    "raw copy moved in lock-out update")
  `SD_ASSERT(a_idle_hold, !proc_i |=> $stable(deb_q) && $stable(lct_q), "state moved while idle")

endmodule

### rtl/core/sd_out_stage.sv
// ----------------------------------------------------------------------------
// sd_out_stage
// Result register: loads when empty or when its result is transferred.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "switch_debouncer_top_defines.svh"

module sd_out_stage import sd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_valid_i,
  output logic       load_ready_o,
  input  sd_result_t result_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output sd_result_t result_o
);

  logic       valid_q, valid_d;
  sd_result_t result_q;
  logic       load;

  assign load_ready_o = !valid_q || !out_stall_i;
  assign load         = load_valid_i && load_ready_o;
  assign valid_d      = load || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  `SD_ASSERT(a_load_sets_valid, load |=> valid_q, "loaded result not shown")
  `SD_ASSERT(a_flags_excl, !(result_q.rose && result_q.fell) || !valid_q,
    "rose and fell together")

endmodule

### rtl/core/switch_debouncer_top.sv
// ----------------------------------------------------------------------------
// switch_debouncer_top
// Switch debouncer: stable-interval, lock-out and prompt-detection modes.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_stall_o | operation, pin_level, now_ms
//   out     | output    | out_valid_o/out_stall_i | level .. current_duration
//   cfg     | input     | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// One item per cycle sustained while out_stall_i is low; each result passes
// the input register, then the result register, before it is on the outputs.
// The state update uses 32-bit subtracts and a 32-bit compare in sd_core.
// Reset clears state and sets interval_ms to 10 and mode to stable interval.
// A stalled result register holds the item in the input register, which
// then stalls the input channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "switch_debouncer_top_defines.svh"

module switch_debouncer_top import sd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic                 pin_level_i,
  input  logic [TimeW-1:0]     now_ms_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 level_o,
  output logic                 changed_o,
  output logic                 rose_o,
  output logic                 fell_o,
  output logic [TimeW-1:0]     previous_duration_o,
  output logic [TimeW-1:0]     current_duration_o
);

  sd_cfg_t    cfg_q;
  sd_item_t   in_item;
  sd_item_t   s1_item;
  logic       s1_valid;
  logic       out_ready;
  logic       proc;
  sd_result_t core_res;
  sd_result_t out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_ms <= IntervalRst;
      cfg_q.mode        <= MODE_STABLE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INTERVAL: cfg_q.interval_ms <= cfg_wdata_i[IntervalW-1:0];
        CFG_MODE:     cfg_q.mode        <= cfg_wdata_i[ModeW-1:0];
        default:      cfg_q             <= cfg_q;
      endcase
    end
  end

  assign in_item.operation = operation_i;
  assign in_item.pin_level = pin_level_i;
  assign in_item.now_ms    = now_ms_i;

  assign proc = s1_valid && out_ready;

  sd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .valid_o    (s1_valid),
    .take_i     (out_ready),
    .item_o     (s1_item)
  );

  sd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .proc_i   (proc),
    .item_i   (s1_item),
    .cfg_i    (cfg_q),
    .result_o (core_res)
  );

  sd_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (s1_valid),
    .load_ready_o (out_ready),
    .result_i     (core_res),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (out_res)
  );

  assign level_o             = out_res.level;
  assign changed_o           = out_res.changed;
  assign rose_o              = out_res.rose;
  assign fell_o              = out_res.fell;
  assign previous_duration_o = out_res.previous_duration;
  assign current_duration_o  = out_res.current_duration;

  `SD_ASSERT(a_stall_needs_item, in_stall_o |-> s1_valid, "input stalled with empty register")
  `SD_ASSERT(a_proc_fills_out, proc |=> out_valid_o, "processed item lost")

endmodule
